>>> sv/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> sv/gtpu_pkg.sv
// Types and constants for the graphics tag packet unpacker.
package gtpu_pkg;

    localparam int unsigned LOOP_W = 15;
    localparam int unsigned POS_W  = 5;
    localparam int unsigned FMT_W  = 2;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned REG_W  = 4;

    localparam int unsigned PRIM_BIT = 46;
    localparam int unsigned FMT_LSB  = 58;
    localparam int unsigned NREG_LSB = 60;

    localparam logic [POS_W-1:0] FULL_LIST = 5'd16;

    localparam logic [KIND_W-1:0] KIND_PACKED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REG     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RAW     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TAG_ACC = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TAG_REJ = 3'd4;

    localparam logic [FMT_W-1:0] FMT_PACKED  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_REGLIST = 2'd1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [REG_W-1:0]  target_reg;
        logic [63:0]       word_lo;
        logic [63:0]       word_hi;
        logic              transfer_done;
        logic              last;
    } result_t;

    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } result_pair_t;

endpackage

>>> sv/gtpu_core.sv
// Tag decode, unpack state and per-quadword result generation.
module gtpu_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [63:0]          data_lo,
    input  logic [63:0]          data_hi,
    output gtpu_pkg::result_pair_t res
);

    logic                          held_reg, held_next;
    logic [gtpu_pkg::FMT_W-1:0]    fmt_reg, fmt_next;
    logic [gtpu_pkg::LOOP_W-1:0]   loops_reg, loops_next;
    logic [gtpu_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [gtpu_pkg::POS_W-1:0]    rpl_reg, rpl_next;
    logic [63:0]                   list_reg, list_next;

    logic [gtpu_pkg::POS_W-1:0]    pos1, pos_a, pos2, pos_b;
    logic [gtpu_pkg::LOOP_W-1:0]   loops_a, loops_b, loops_i, nloop;
    logic                          wrap1, wrap2, done1, done2, done_i;
    logic [gtpu_pkg::REG_W-1:0]    cur0, cur1, nregs;

    always_comb
    begin
        // first register slot
        cur0    = list_reg[{pos_reg[3:0], 2'b00} +: 4];
        pos1    = pos_reg + 5'd1;
        wrap1   = (pos1 >= rpl_reg);
        pos_a   = wrap1 ? '0 : pos1;
        loops_a = wrap1 ? loops_reg - 15'd1 : loops_reg;
        done1   = wrap1 && (loops_a == '0);
        // second slot, REGLIST high dword
        cur1    = list_reg[{pos_a[3:0], 2'b00} +: 4];
        pos2    = pos_a + 5'd1;
        wrap2   = (pos2 >= rpl_reg);
        pos_b   = wrap2 ? '0 : pos2;
        loops_b = wrap2 ? loops_a - 15'd1 : loops_a;
        done2   = wrap2 && (loops_b == '0);
        // IMAGE
        loops_i = loops_reg - 15'd1;
        done_i  = (loops_i == '0);
        // tag fields
        nloop   = data_lo[gtpu_pkg::LOOP_W-1:0];
        nregs   = data_lo[gtpu_pkg::NREG_LSB +: 4];

        held_next  = held_reg;
        fmt_next   = fmt_reg;
        loops_next = loops_reg;
        pos_next   = pos_reg;
        rpl_next   = rpl_reg;
        list_next  = list_reg;
        res        = '0;

        if (!held_reg)
        begin
            res.first.last = 1'b1;
            if ((nloop == '0) || data_lo[gtpu_pkg::PRIM_BIT])
            begin
                res.first.kind = gtpu_pkg::KIND_TAG_REJ;
            end
            else
            begin
                res.first.kind = gtpu_pkg::KIND_TAG_ACC;
                held_next  = 1'b1;
                fmt_next   = data_lo[gtpu_pkg::FMT_LSB +: 2];
                loops_next = nloop;
                pos_next   = '0;
                rpl_next   = (nregs == '0) ? gtpu_pkg::FULL_LIST : {1'b0, nregs};
                list_next  = data_hi;
            end
        end
        else
        begin
            case (fmt_reg)
                gtpu_pkg::FMT_PACKED:
                begin
                    res.first.kind          = gtpu_pkg::KIND_PACKED;
                    res.first.target_reg    = cur0;
                    res.first.word_lo       = data_lo;
                    res.first.word_hi       = data_hi;
                    res.first.transfer_done = done1;
                    res.first.last          = 1'b1;
                    pos_next   = pos_a;
                    loops_next = loops_a;
                    held_next  = !done1;
                end
                gtpu_pkg::FMT_REGLIST:
                begin
                    res.first.kind       = gtpu_pkg::KIND_REG;
                    res.first.target_reg = cur0;
                    res.first.word_lo    = data_lo;
                    if (done1)
                    begin
                        // transfer ends on low dword, high dword dropped
                        res.first.transfer_done = 1'b1;
                        res.first.last          = 1'b1;
                        pos_next   = pos_a;
                        loops_next = loops_a;
                        held_next  = 1'b0;
                    end
                    else
                    begin
                        res.two                  = 1'b1;
                        res.second.kind          = gtpu_pkg::KIND_REG;
                        res.second.target_reg    = cur1;
                        res.second.word_lo       = data_hi;
                        res.second.transfer_done = done2;
                        res.second.last          = 1'b1;
                        pos_next   = pos_b;
                        loops_next = loops_b;
                        held_next  = !done2;
                    end
                end
                default:
                begin
                    res.two                  = 1'b1;
                    res.first.kind           = gtpu_pkg::KIND_RAW;
                    res.first.word_lo        = data_lo;
                    res.second.kind          = gtpu_pkg::KIND_RAW;
                    res.second.word_lo       = data_hi;
                    res.second.transfer_done = done_i;
                    res.second.last          = 1'b1;
                    loops_next = loops_i;
                    held_next  = !done_i;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 1'b0;
            fmt_reg   <= '0;
            loops_reg <= '0;
            pos_reg   <= '0;
            rpl_reg   <= gtpu_pkg::FULL_LIST;
            list_reg  <= '0;
        end
        else if (step)
        begin
            held_reg  <= held_next;
            fmt_reg   <= fmt_next;
            loops_reg <= loops_next;
            pos_reg   <= pos_next;
            rpl_reg   <= rpl_next;
            list_reg  <= list_next;
        end
    end

endmodule

>>> sv/graphics_tag_packet_unpacker.sv
// Graphics tag packet unpacker top level: input register, core, result queue.
// Takes one 128-bit quadword per cycle, while in_stall is low, into an input
// register; the core turns it into one result word (tags, PACKED writes,
// REGLIST writes at transfer end) or two (REGLIST, IMAGE) that go into a
// four-entry result queue. The single result port drains one word per cycle
// while out_stall is low, so the sustained rate is one quadword per cycle for
// one-word items, while two-word items are paced by that port. A quadword's
// results pass through the input register and the result queue to the port.
module graphics_tag_packet_unpacker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_lo,
    input  logic [63:0] data_hi,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [3:0]  target_reg,
    output logic [63:0] word_lo,
    output logic [63:0] word_hi,
    output logic        transfer_done,
    output logic        last
);

    localparam int unsigned DEPTH = 4;

    logic                  in_vld_reg, in_vld_next;
    logic [63:0]           lo_reg, hi_reg;
    logic                  accept, step, pop, room;
    gtpu_pkg::result_pair_t res;

    gtpu_pkg::result_t     fifo_reg [DEPTH];
    logic [1:0]            wr_ptr_reg, rd_ptr_reg;
    logic [2:0]            count_reg, count_next, count_left;
    gtpu_pkg::result_t     head;

    gtpu_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .data_lo (lo_reg),
        .data_hi (hi_reg),
        .res     (res)
    );

    assign pop        = out_valid && !out_stall;
    assign count_left = count_reg - {2'b00, pop};
    assign room       = (count_left <= 3'd2);
    assign step       = in_vld_reg && room;
    assign in_stall   = in_vld_reg && !step;
    assign accept     = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end
        count_next = count_left;
        if (step)
        begin
            count_next = count_left + (res.two ? 3'd2 : 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            if (step)
            begin
                wr_ptr_reg <= wr_ptr_reg + (res.two ? 2'd2 : 2'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg <= data_lo;
            hi_reg <= data_hi;
        end
        if (step)
        begin
            fifo_reg[wr_ptr_reg] <= res.first;
            if (res.two)
            begin
                fifo_reg[wr_ptr_reg + 2'd1] <= res.second;
            end
        end
    end

    assign head          = fifo_reg[rd_ptr_reg];
    assign out_valid     = (count_reg != '0);
    assign kind          = head.kind;
    assign target_reg    = head.target_reg;
    assign word_lo       = head.word_lo;
    assign word_hi       = head.word_hi;
    assign transfer_done = head.transfer_done;
    assign last          = head.last;

endmodule

>>> sv/gtpu_checker.sv
// Port-level checks for the graphics tag packet unpacker, with bind.
`include "assert_macros.svh"

module gtpu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  kind,
    input logic [3:0]  target_reg,
    input logic [63:0] word_lo,
    input logic [63:0] word_hi,
    input logic        transfer_done,
    input logic        last
);

    `ASSERT_ALWAYS(a_idle_in_reset, clk, !rst_n |=> !out_valid, "result valid during reset")

    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(kind) && $stable(word_lo) && $stable(last), "stalled result word changed")

    `ASSERT_CLK(a_tag_clean, clk, rst_n, out_valid && (kind == gtpu_pkg::KIND_TAG_ACC || kind == gtpu_pkg::KIND_TAG_REJ) |-> target_reg == '0 && word_lo == '0 && word_hi == '0 && last && !transfer_done, "tag event carries data")

    `ASSERT_CLK(a_first_of_two, clk, rst_n, out_valid && !last |-> (kind == gtpu_pkg::KIND_REG || kind == gtpu_pkg::KIND_RAW) && !transfer_done, "bad first word of a pair")

    `ASSERT_CLK(a_packed_single, clk, rst_n, out_valid && kind == gtpu_pkg::KIND_PACKED |-> last, "packed write not last")

endmodule

bind graphics_tag_packet_unpacker gtpu_checker u_gtpu_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .target_reg    (target_reg),
    .word_lo       (word_lo),
    .word_hi       (word_hi),
    .transfer_done (transfer_done),
    .last          (last)
);

>>> sim/tb_top.sv
// Self-checking testbench for the graphics tag packet unpacker.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [gtpu_pkg::FMT_W-1:0] FMT_IMAGE     = 2'd2;
    localparam logic [gtpu_pkg::FMT_W-1:0] FMT_IMAGE_ALT = 2'd3;
    localparam int unsigned                HOLD_CYCLES   = 400;
    localparam int unsigned                PHASE_WORDS   = 475;

    class unpacker_scoreboard;
        logic                        tag_held;
        logic [gtpu_pkg::FMT_W-1:0]  format_mode;
        logic [gtpu_pkg::LOOP_W-1:0] loops_left;
        logic [gtpu_pkg::POS_W-1:0]  reg_pos;
        logic [gtpu_pkg::POS_W-1:0]  regs_per_loop;
        logic [63:0]                 reg_list;
        gtpu_pkg::result_t           pending_writes[$];
        int                          n_quadwords;
        int                          n_results;
        int                          n_tags_taken;
        int                          n_tags_refused;
        int                          errors;

        function new();
            tag_held       = 1'b0;
            format_mode    = gtpu_pkg::FMT_PACKED;
            loops_left     = '0;
            reg_pos        = '0;
            regs_per_loop  = gtpu_pkg::FULL_LIST;
            reg_list       = '0;
            n_quadwords    = 0;
            n_results      = 0;
            n_tags_taken   = 0;
            n_tags_refused = 0;
            errors         = 0;
        endfunction

        function void add_expected(logic [gtpu_pkg::KIND_W-1:0] k,
                                   logic [gtpu_pkg::REG_W-1:0] r,
                                   logic [63:0] lo, logic [63:0] hi,
                                   logic done, logic fin);
            gtpu_pkg::result_t e;
            e.kind          = k;
            e.target_reg    = r;
            e.word_lo       = lo;
            e.word_hi       = hi;
            e.transfer_done = done;
            e.last          = fin;
            pending_writes.push_back(e);
        endfunction

        function logic [gtpu_pkg::REG_W-1:0] list_entry();
            return reg_list[4 * reg_pos[3:0] +: 4];
        endfunction

        // Moves to the next list entry; returns 1 when the transfer ends.
        function logic step_register();
            reg_pos = reg_pos + 1'b1;
            if (reg_pos >= regs_per_loop)
            begin
                reg_pos    = '0;
                loops_left = loops_left - 1'b1;
                if (loops_left == '0)
                begin
                    tag_held = 1'b0;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_quadword(logic [63:0] lo, logic [63:0] hi);
            logic [gtpu_pkg::REG_W-1:0] r;
            logic                       done;
            n_quadwords++;
            if (!tag_held)
            begin
                if (lo[gtpu_pkg::LOOP_W-1:0] == '0 || lo[gtpu_pkg::PRIM_BIT])
                begin
                    n_tags_refused++;
                    add_expected(gtpu_pkg::KIND_TAG_REJ, '0, '0, '0, 1'b0, 1'b1);
                end
                else
                begin
                    n_tags_taken++;
                    tag_held      = 1'b1;
                    format_mode   = lo[gtpu_pkg::FMT_LSB +: gtpu_pkg::FMT_W];
                    loops_left    = lo[gtpu_pkg::LOOP_W-1:0];
                    reg_pos       = '0;
                    regs_per_loop = (lo[gtpu_pkg::NREG_LSB +: 4] == 4'd0)
                                    ? gtpu_pkg::FULL_LIST
                                    : {1'b0, lo[gtpu_pkg::NREG_LSB +: 4]};
                    reg_list      = hi;
                    add_expected(gtpu_pkg::KIND_TAG_ACC, '0, '0, '0, 1'b0, 1'b1);
                end
            end
            else if (format_mode == gtpu_pkg::FMT_PACKED)
            begin
                r    = list_entry();
                done = step_register();
                add_expected(gtpu_pkg::KIND_PACKED, r, lo, hi, done, 1'b1);
            end
            else if (format_mode == gtpu_pkg::FMT_REGLIST)
            begin
                r    = list_entry();
                done = step_register();
                add_expected(gtpu_pkg::KIND_REG, r, lo, '0, done, done);
                // second dword dropped only when the first ends the transfer
                if (!done)
                begin
                    r    = list_entry();
                    done = step_register();
                    add_expected(gtpu_pkg::KIND_REG, r, hi, '0, done, 1'b1);
                end
            end
            else
            begin
                loops_left = loops_left - 1'b1;
                done       = (loops_left == '0);
                if (done)
                    tag_held = 1'b0;
                add_expected(gtpu_pkg::KIND_RAW, '0, lo, '0, 1'b0, 1'b0);
                add_expected(gtpu_pkg::KIND_RAW, '0, hi, '0, done, 1'b1);
            end
        endfunction

        task report_mismatch(string what);
            if (errors < 100)
                $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h want %h (result %0d)",
                                          name, got, want, n_results));
        endtask

        task check_result(gtpu_pkg::result_t got);
            gtpu_pkg::result_t want;
            n_results++;
            if (pending_writes.size() == 0)
            begin
                report_mismatch("result word with nothing pending");
                return;
            end
            want = pending_writes.pop_front();
            compare_field("kind", got.kind, want.kind);
            compare_field("target_reg", got.target_reg, want.target_reg);
            compare_field("word_lo", got.word_lo, want.word_lo);
            compare_field("word_hi", got.word_hi, want.word_hi);
            compare_field("transfer_done", got.transfer_done, want.transfer_done);
            compare_field("last", got.last, want.last);
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [63:0] data_lo   = '0;
    logic [63:0] data_hi   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [3:0]  target_reg;
    logic [63:0] word_lo;
    logic [63:0] word_hi;
    logic        transfer_done;
    logic        last;

    logic        hold_go   = 1'b0;
    logic        hold_on   = 1'b0;
    int          idle_pct  = 0;
    int          stall_pct = 0;

    unpacker_scoreboard sb = new();

    graphics_tag_packet_unpacker uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_lo       (data_lo),
        .data_hi       (data_hi),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .target_reg    (target_reg),
        .word_lo       (word_lo),
        .word_hi       (word_hi),
        .transfer_done (transfer_done),
        .last          (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        @(posedge hold_go);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    always @(posedge clk)
    begin
        gtpu_pkg::result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind          = kind;
            got.target_reg    = target_reg;
            got.word_lo       = word_lo;
            got.word_hi       = word_hi;
            got.transfer_done = transfer_done;
            got.last          = last;
            sb.check_result(got);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] data_word();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '1;
        if (pick == 1)
            return '0;
        return rand64();
    endfunction

    function automatic logic [63:0] make_tag(logic [gtpu_pkg::FMT_W-1:0] fmt,
                                             logic [gtpu_pkg::LOOP_W-1:0] nloop,
                                             logic [3:0] nregs, logic prim,
                                             logic [63:0] filler);
        logic [63:0] t;
        t                                        = filler;
        t[gtpu_pkg::LOOP_W-1:0]                  = nloop;
        t[gtpu_pkg::PRIM_BIT]                    = prim;
        t[gtpu_pkg::FMT_LSB +: gtpu_pkg::FMT_W]  = fmt;
        t[gtpu_pkg::NREG_LSB +: 4]               = nregs;
        return t;
    endfunction

    task automatic push_quadword(logic [63:0] lo, logic [63:0] hi);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_lo  <= lo;
        data_hi  <= hi;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_quadword(lo, hi);
    endtask

    task automatic send_packet(logic [gtpu_pkg::FMT_W-1:0] fmt, int nloop, logic [3:0] nregs);
        int per_loop;
        int count;
        per_loop = (nregs == 4'd0) ? 16 : nregs;
        push_quadword(make_tag(fmt, nloop, nregs, 1'b0, rand64()), rand64());
        if (fmt == gtpu_pkg::FMT_PACKED)
            count = nloop * per_loop;
        else if (fmt == gtpu_pkg::FMT_REGLIST)
            count = (nloop * per_loop + 1) / 2;
        else
            count = nloop;
        repeat (count) push_quadword(data_word(), data_word());
    endtask

    task automatic send_refused_tag();
        logic [63:0] t;
        t = rand64();
        if ($urandom_range(0, 1) == 0)
            t[gtpu_pkg::LOOP_W-1:0] = '0;
        else
            t[gtpu_pkg::PRIM_BIT] = 1'b1;
        push_quadword(t, rand64());
    endtask

    task automatic run_random(int words);
        int start;
        int nloop;
        start = sb.n_quadwords;
        while (sb.n_quadwords - start < words)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                nloop = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8)
                                                    : $urandom_range(1, 3);
                send_packet($urandom_range(0, 3), nloop, $urandom_range(0, 15));
            end
            else
                send_refused_tag();
        end
    endtask

    initial
    begin
        #(5_000_000);
        $display("Timeout: %0d results still pending", sb.pending_writes.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // refused tags: zero loop count, then all ones (max loop with PRIM)
        push_quadword('0, '1);
        push_quadword('1, '1);
        // packed, two registers (list entries 15 and 1), extreme data
        push_quadword(make_tag(gtpu_pkg::FMT_PACKED, 1, 4'd2, 1'b0, '0),
                      64'h0000_0000_0000_001F);
        push_quadword('1, '0);
        push_quadword('0, '1);
        // reglist ending on the first dword of a quadword
        push_quadword(make_tag(gtpu_pkg::FMT_REGLIST, 1, 4'd3, 1'b0, '0),
                      64'h0000_0000_0000_0A5F);
        push_quadword(64'h1111_1111_1111_1111, 64'h2222_2222_2222_2222);
        push_quadword(64'h3333_3333_3333_3333, 64'h4444_4444_4444_4444);
        // reglist whose loop ends mid-quadword and carries on
        push_quadword(make_tag(gtpu_pkg::FMT_REGLIST, 2, 4'd1, 1'b0, '1),
                      64'h0000_0000_0000_0007);
        push_quadword('1, '1);
        send_packet(FMT_IMAGE, 2, 4'd5);
        send_packet(FMT_IMAGE_ALT, 1, 4'd0);
        push_quadword(make_tag(gtpu_pkg::FMT_REGLIST, 1, 4'd0, 1'b0, '0),
                      64'hFEDC_BA98_7654_3210);
        repeat (8) push_quadword(data_word(), data_word());

        idle_pct  = 0;
        stall_pct <= 0;
        hold_go   <= 1'b1;
        run_random(PHASE_WORDS);

        idle_pct  = 84;
        stall_pct <= 0;
        run_random(PHASE_WORDS);

        idle_pct  = 0;
        stall_pct <= 84;
        run_random(PHASE_WORDS);

        idle_pct  = 21;
        stall_pct <= 21;
        run_random(PHASE_WORDS);

        in_valid <= 1'b0;
        while (sb.pending_writes.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Run covered %0d quadwords: %0d tags taken, %0d tags refused, %0d result words",
                 sb.n_quadwords, sb.n_tags_taken, sb.n_tags_refused, sb.n_results);
        $display("across free-flowing, sender-idle, receiver-stall and mixed traffic, %0d errors",
                 sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
